/* src/hurwitz_table_tau_test_top_assert.svh */
// Assertion macros for the Hurwitz table and prime test block.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef HURWITZ_TABLE_TAU_TEST_TOP_ASSERT_SVH
`define HURWITZ_TABLE_TAU_TEST_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define HWTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HWTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/hwtt_pkg.sv */
// Shared constants, types and tables for the Hurwitz table and prime test block.
// No dependencies.
`timescale 1ns / 1ps
package hwtt_pkg;

  localparam int TABLE_DEPTH = 32768;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = 16;
  localparam int MOD_W       = 17;
  localparam int X_W         = 33;
  localparam int D_W         = 18;

  localparam logic [1:0] REQ_GEN  = 2'd0;
  localparam logic [1:0] REQ_TEST = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_RSVD = 2'd3;

  localparam logic [2:0] W_SQUARE = 3'd3;
  localparam logic [2:0] W_HEX    = 3'd2;
  localparam logic [2:0] W_PLAIN  = 3'd6;

  // Forward differences of t^10 at t = 1, followed by the constant 1008.
  localparam logic [25:0] INIT_CONST [12] = '{
    26'd1, 26'd1023, 26'd57002, 26'd874500, 26'd5921520, 26'd21538440,
    26'd46070640, 26'd59875200, 26'd46569600, 26'd19958400, 26'd3628800, 26'd1008
  };

  typedef struct packed {
    logic             start;
    logic [X_W-1:0]   x;
    logic [MOD_W-1:0] m;
  } modred_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] rem;
  } modred_rsp_t;

endpackage

/* src/hwtt_modred.sv */
// Bit-serial modular reduction: remainder of a 33-bit value by a 17-bit modulus.
// Depends on hwtt_pkg.
`timescale 1ns / 1ps
module hwtt_modred
  import hwtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  modred_req_t req,
  output modred_rsp_t rsp
);

  logic [X_W-1:0]         x_r;
  logic [MOD_W-1:0]       rem_r;
  logic [MOD_W-1:0]       m_r;
  logic [$clog2(X_W)-1:0] cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic [MOD_W:0]         shifted;
  logic [MOD_W-1:0]       rem_nxt;

  always_comb begin
    shifted = {rem_r, x_r[X_W-1]};
    if (shifted >= {1'b0, m_r}) begin
      rem_nxt = MOD_W'(shifted - {1'b0, m_r});
    end else begin
      rem_nxt = shifted[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        x_r    <= req.x;
        m_r    <= req.m;
        rem_r  <= '0;
        cnt_r  <= ($clog2(X_W))'(X_W - 1);
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        x_r   <= {x_r[X_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

/* src/hurwitz_table_tau_test_top.sv */
// A read result passes S_RD, S_RD2 and S_DONE once its request is accepted; a test result
// waits on the serial reduction unit for each seed and each product, t = 1 to isqrt(4p).
// A generate visits S_GA per a, S_GB per b, S_GC and S_GW per form and S_GC per skipped c.
// One request is in work at a time; the next can be taken in the cycle its result appears.
// After reset a clearing pass writes zero to all 32768 entries, one a cycle, before any request.
// Top level of the Hurwitz table block; depends on hwtt_pkg, hwtt_modred and the assert header.
`timescale 1ns / 1ps
`include "hurwitz_table_tau_test_top_assert.svh"
module hurwitz_table_tau_test_top
  import hwtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // range_low [15:0], range_high [31:16], prime [45:32], entry_index [60:46]
  input  logic [63:0] in_tdata,
  // req_type [1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // entry_value [15:0], match [16], residue_sum [33:17]
  output logic [39:0] out_tdata
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_RD2, S_GA, S_GB, S_GC, S_GW,
    S_TI, S_TIW, S_TT, S_TR, S_TM, S_TW, S_DONE
  } state_t;

  state_t             state_r;
  logic [IDX_W-1:0]   clr_cnt_r;
  logic [15:0]        lo_r, hi_r;
  logic [13:0]        p_r;
  logic [IDX_W-1:0]   eidx_r;
  logic [7:0]         a_r;
  logic signed [8:0]  b_r;
  logic               c_first_r;
  logic [D_W-1:0]     d_r;
  logic [MOD_W-1:0]   mod_r;
  logic [MOD_W-1:0]   diff_r [11];
  logic [MOD_W-1:0]   sum_r;
  logic [8:0]         t_r;
  logic [3:0]         k_r;
  logic [X_W-1:0]     prod_r;
  logic [ENTRY_W-1:0] res_entry_r;
  logic               res_match_r;
  logic [MOD_W-1:0]   res_sum_r;
  logic               out_valid_r;
  logic [39:0]        out_data_r;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] mem_rdata_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;

  modred_req_t        mreq;
  modred_rsp_t        mrsp;

  logic [15:0]        a_sq;
  logic [7:0]         b_abs;
  logic [15:0]        b_sq;
  logic [D_W-1:0]     d_first;
  logic [D_W-1:0]     step4a;
  logic               b_is_a;
  logic [2:0]         weight;
  logic [ENTRY_W:0]   bumped;
  logic               d_beyond;
  logic [17:0]        t_sq;
  logic [15:0]        four_p;
  logic [15:0]        t_gap;
  logic [MOD_W:0]     sum_add;
  logic [MOD_W-1:0]   sum_nxt;
  logic [MOD_W-1:0]   diff_nxt [11];
  logic [MOD_W:0]     diff_add [10];
  logic [13:0]        p_m1;

  hwtt_modred u_modred (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  always_comb begin
    a_sq     = a_r * a_r;
    b_abs    = b_r[8] ? 8'(-b_r) : b_r[7:0];
    b_sq     = b_abs * b_abs;
    step4a   = D_W'({a_r, 2'b00});
    d_first  = D_W'({a_sq, 2'b00}) - D_W'(b_sq);
    b_is_a   = (b_r == $signed({1'b0, a_r}));
    if (c_first_r && (b_r == 9'sd0)) begin
      weight = W_SQUARE;
    end else if (c_first_r && b_is_a) begin
      weight = W_HEX;
    end else begin
      weight = W_PLAIN;
    end
    bumped   = {1'b0, mem_rdata_r} + (ENTRY_W + 1)'(weight);
    d_beyond = (d_r[D_W-1:IDX_W+1] != '0);
    t_sq     = 18'(t_r * t_r);
    four_p   = {p_r, 2'b00};
    t_gap    = four_p - t_sq[15:0];
    sum_add  = {1'b0, sum_r} + {1'b0, mrsp.rem};
    sum_nxt  = (sum_add >= {1'b0, mod_r}) ? MOD_W'(sum_add - {1'b0, mod_r})
                                          : sum_add[MOD_W-1:0];
    for (int k = 0; k < 10; k++) begin
      diff_add[k] = {1'b0, diff_r[k]} + {1'b0, diff_r[k+1]};
      diff_nxt[k] = (diff_add[k] >= {1'b0, mod_r}) ? MOD_W'(diff_add[k] - {1'b0, mod_r})
                                                    : diff_add[k][MOD_W-1:0];
    end
    diff_nxt[10] = diff_r[10];
    p_m1     = in_tdata[45:32] - 14'd1;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = '0;
    mem_raddr = eidx_r;
    unique case (state_r)
      S_CLR: mem_we = 1'b1;
      S_GC:  mem_raddr = d_r[IDX_W:1];
      S_GW: begin
        mem_we    = !d_beyond;
        mem_waddr = d_r[IDX_W:1];
        mem_wdata = bumped[ENTRY_W] ? '1 : bumped[ENTRY_W-1:0];
      end
      S_TT:  mem_raddr = t_gap[IDX_W:1];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    mreq.start = (state_r == S_TI) || (state_r == S_TM);
    mreq.x     = (state_r == S_TI) ? X_W'(INIT_CONST[k_r]) : prod_r;
    mreq.m     = mod_r;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == IDX_W'(TABLE_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            lo_r        <= in_tdata[15:0];
            hi_r        <= in_tdata[31:16];
            p_r         <= in_tdata[45:32];
            eidx_r      <= in_tdata[60:46];
            res_entry_r <= '0;
            res_match_r <= 1'b0;
            res_sum_r   <= '0;
            a_r         <= 8'd1;
            k_r         <= '0;
            mod_r       <= MOD_W'({p_m1, 2'b00}) + MOD_W'({p_m1, 1'b0});
            unique case (in_tuser)
              REQ_GEN:  state_r <= (in_tdata[15:0] > in_tdata[31:16]) ? S_DONE : S_GA;
              REQ_TEST: state_r <= (in_tdata[45:32] < 14'd2) ? S_DONE : S_TI;
              REQ_READ: state_r <= S_RD;
              default:  state_r <= S_DONE;
            endcase
          end
        end
        S_RD:  state_r <= S_RD2;
        S_RD2: begin
          res_entry_r <= mem_rdata_r;
          state_r     <= S_DONE;
        end
        S_GA: begin
          if ((18'(a_sq) + 18'({a_sq, 1'b0})) > 18'(hi_r)) begin
            state_r <= S_DONE;
          end else begin
            b_r     <= 9'sd1 - $signed({1'b0, a_r});
            state_r <= S_GB;
          end
        end
        S_GB: begin
          if (b_r[8]) begin
            d_r       <= d_first + step4a;
            c_first_r <= 1'b0;
          end else begin
            d_r       <= d_first;
            c_first_r <= 1'b1;
          end
          state_r <= S_GC;
        end
        S_GC: begin
          if (d_r > D_W'(hi_r)) begin
            if (b_is_a) begin
              a_r     <= a_r + 8'd1;
              state_r <= S_GA;
            end else begin
              b_r     <= b_r + 9'sd1;
              state_r <= S_GB;
            end
          end else if (d_r < D_W'(lo_r)) begin
            d_r       <= d_r + step4a;
            c_first_r <= 1'b0;
          end else begin
            state_r <= S_GW;
          end
        end
        S_GW: begin
          d_r       <= d_r + step4a;
          c_first_r <= 1'b0;
          state_r   <= S_GC;
        end
        S_TI:  state_r <= S_TIW;
        S_TIW: begin
          if (mrsp.done) begin
            if (k_r == 4'd11) begin
              sum_r   <= mrsp.rem;
              t_r     <= 9'd1;
              state_r <= S_TT;
            end else begin
              diff_r[k_r] <= mrsp.rem;
              k_r         <= k_r + 4'd1;
              state_r     <= S_TI;
            end
          end
        end
        S_TT: begin
          if (t_sq > 18'(four_p)) begin
            res_sum_r   <= sum_r;
            res_match_r <= (sum_r == '0);
            state_r     <= S_DONE;
          end else begin
            state_r <= S_TR;
          end
        end
        S_TR: begin
          prod_r  <= X_W'(diff_r[0] * mem_rdata_r);
          state_r <= S_TM;
        end
        S_TM: state_r <= S_TW;
        S_TW: begin
          if (mrsp.done) begin
            sum_r  <= sum_nxt;
            diff_r <= diff_nxt;
            t_r    <= t_r + 9'd1;
            state_r <= S_TT;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {6'd0, res_sum_r, res_match_r, res_entry_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_CLR;
      endcase
    end
  end

  `HWTT_ASSERT_IMP(a_clear_blocks, state_r == S_CLR, !in_tready, "request taken while clearing")
  `HWTT_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request taken while busy")
  `HWTT_ASSERT_IMP(a_mod_range, mrsp.done, mrsp.rem < mod_r, "remainder not below modulus")
  `HWTT_ASSERT_IMP(a_write_states, mem_we, state_r == S_CLR || state_r == S_GW, "stray table write")

endmodule

/* verif/hurwitz_table_tau_test_top_test.sv */
// Testbench for the Hurwitz class number table block: generate, prime test and read requests.
// Predicts every result with its own copy of the table and checks each one in order.
// Depends on hwtt_pkg and the top level hurwitz_table_tau_test_top.
`timescale 1ns / 1ps
module hurwitz_table_tau_test_top_test
  import hwtt_pkg::*;
();

  typedef struct packed {
    logic [16:0] residue_sum;
    logic        match;
    logic [15:0] entry_value;
  } tally_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  logic [15:0] class_table [TABLE_DEPTH];
  tally_t      pending_tallies [$];
  int          mismatch_count = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cycles = 0;

  hurwitz_table_tau_test_top i_dut (.*);

  always #5 clk = ~clk;

  function automatic longint isqrt_floor(longint n);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  function automatic logic [15:0] class_entry(longint idx);
    if (idx >= TABLE_DEPTH) return '0;
    return class_table[idx];
  endfunction

  function automatic void add_form_weight(longint disc, int weight);
    longint idx;
    int     v;
    idx = disc >> 1;
    if (idx >= TABLE_DEPTH) return;
    v = class_table[idx] + weight;
    if (v > 65535) v = 65535;
    class_table[idx] = v[15:0];
  endfunction

  function automatic void enumerate_forms(longint lo, longint hi);
    longint a, amax, c, c0, c1, step, bsq, b;
    int     w;
    if (lo > hi) return;
    amax = isqrt_floor(hi / 3);
    for (a = 1; a <= amax; a++) begin
      step = 4 * a;
      for (b = 1 - a; b <= a; b++) begin
        bsq = b * b;
        c0 = (lo + bsq + step - 1) / step;
        c1 = (hi + bsq) / step;
        if (c0 < a) c0 = a;
        if (b < 0 && c0 == a) c0++;
        for (c = c0; c <= c1; c++) begin
          w = W_PLAIN;
          if (c == a && b == 0) w = W_SQUARE;
          else if (c == a && b == a) w = W_HEX;
          add_form_weight(step * c - bsq, w);
        end
      end
    end
  endfunction

  function automatic longint tau_residue(longint p);
    longint modulus, total, t, tmax, h;
    longint diffs [11];
    longint seeds [11];
    seeds = '{1, 1023, 57002, 874500, 5921520, 21538440, 46070640,
              59875200, 46569600, 19958400, 3628800};
    modulus = 6 * (p - 1);
    total = 1008 % modulus;
    for (int k = 0; k <= 10; k++) diffs[k] = seeds[k] % modulus;
    tmax = isqrt_floor(4 * p);
    for (t = 1; t <= tmax; t++) begin
      h = class_entry((4 * p - t * t) >> 1);
      total += (diffs[0] * h) % modulus;
      if (total >= modulus) total -= modulus;
      for (int k = 0; k < 10; k++) begin
        diffs[k] += diffs[k + 1];
        if (diffs[k] >= modulus) diffs[k] -= modulus;
      end
    end
    return total;
  endfunction

  function automatic tally_t predict_request(logic [1:0] kind, logic [63:0] data);
    tally_t r;
    longint s;
    r = '0;
    case (kind)
      REQ_GEN: enumerate_forms(data[15:0], data[31:16]);
      REQ_TEST: begin
        if (data[45:32] >= 2) begin
          s = tau_residue(data[45:32]);
          r.match = (s == 0);
          r.residue_sum = s[16:0];
        end
      end
      REQ_READ: r.entry_value = class_entry(data[60:46]);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(logic [1:0] kind, logic [15:0] lo, logic [15:0] hi,
                              logic [13:0] p, logic [14:0] idx);
    int gap;
    if ($urandom_range(99) < send_gap_pct) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, idx, p, hi, lo};
    do @(posedge clk); while (!in_tready);
    pending_tallies.push_back(predict_request(kind, {3'b000, idx, p, hi, lo}));
  endtask

  task automatic send_random_request();
    logic [15:0] lo, hi;
    int          pick;
    pick = $urandom_range(99);
    hi = ($urandom_range(9) == 0) ? 16'($urandom_range(1, 65535))
                                  : 16'($urandom_range(1, 3000));
    lo = 16'(hi - $urandom_range(0, (hi > 300) ? 300 : hi - 1));
    if ($urandom_range(9) == 0) lo = 16'(hi + $urandom_range(1, 50));
    if (pick < 30)
      send_request(REQ_GEN, lo, hi, 14'($urandom), 15'($urandom));
    else if (pick < 60)
      send_request(REQ_TEST, 16'($urandom), 16'($urandom),
                   14'($urandom_range(0, 16383)), 15'($urandom));
    else if (pick < 95)
      send_request(REQ_READ, 16'($urandom), 16'($urandom), 14'($urandom),
                   ($urandom_range(3) == 0) ? 15'($urandom_range(0, 32767))
                                            : 15'($urandom_range(0, 1600)));
    else
      send_request(REQ_RSVD, 16'($urandom), 16'($urandom), 14'($urandom), 15'($urandom));
  endtask

  task automatic test_form_weights();
    send_request(REQ_READ, 0, 0, 0, 15'd0);
    send_request(REQ_READ, 0, 0, 0, 15'h7fff);
    send_request(REQ_GEN, 16'd1, 16'd200, 0, 0);
    send_request(REQ_READ, 0, 0, 0, 15'd1);
    send_request(REQ_READ, 0, 0, 0, 15'd2);
    send_request(REQ_READ, 0, 0, 0, 15'd6);
    send_request(REQ_GEN, 16'd3, 16'd4, 0, 0);
    send_request(REQ_READ, 0, 0, 0, 15'd1);
    send_request(REQ_GEN, 16'd100, 16'd50, 0, 0);
    send_request(REQ_GEN, 16'd65000, 16'd65535, 0, 0);
    send_request(REQ_READ, 0, 0, 0, 15'd32767);
    send_request(REQ_READ, 0, 0, 0, 15'd32500);
  endtask

  task automatic test_prime_sums();
    send_request(REQ_TEST, 0, 0, 14'd0, 0);
    send_request(REQ_TEST, 0, 0, 14'd1, 0);
    send_request(REQ_TEST, 0, 0, 14'd2, 0);
    send_request(REQ_TEST, 0, 0, 14'd11, 0);
    send_request(REQ_TEST, 0, 0, 14'd49, 0);
    send_request(REQ_TEST, 0, 0, 14'd16381, 0);
    send_request(REQ_TEST, 0, 0, 14'h3fff, 0);
  endtask

  task automatic test_unknown_request();
    send_request(REQ_RSVD, 16'hffff, 16'hffff, 14'h3fff, 15'h7fff);
    send_request(REQ_READ, 0, 0, 0, 15'd1);
  endtask

  task automatic test_repeated_generate();
    repeat (4) send_request(REQ_GEN, 16'd4620, 16'd4621, 0, 0);
    send_request(REQ_READ, 0, 0, 0, 15'd2310);
    send_request(REQ_TEST, 0, 0, 14'd1163, 0);
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 3000;
    for (int i = 0; i < 8; i++)
      send_request(REQ_READ, 0, 0, 0, 15'($urandom_range(0, 2400)));
  endtask

  task automatic test_random_mix();
    int gaps [4] = '{0, 49, 0, 17};
    int stalls [4] = '{0, 0, 49, 17};
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct = gaps[ph];
      recv_stall_pct = stalls[ph];
      for (int i = 0; i < 30; i++) send_random_request();
    end
  endtask

  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    tally_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[33:0];
      if (pending_tallies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result %h", out_tdata);
      end else begin
        want = pending_tallies.pop_front();
        if (got !== want || out_tdata[39:34] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected value %0d match %0d sum %0d, got %0d %0d %0d",
                     want.entry_value, want.match, want.residue_sum,
                     got.entry_value, got.match, got.residue_sum);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) class_table[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_form_weights();
    test_prime_sums();
    test_unknown_request();
    test_repeated_generate();
    test_backpressure();
    test_random_mix();
    in_tvalid <= 1'b0;
    wait (pending_tallies.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_tallies.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5s;
    $display("FAILURE");
    $finish;
  end

endmodule
